>>> rtl/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Shared widths, codes and size defaults for the summed-area table query block.
// ----------------------------------------------------------------------------
package satq_pkg;

  // payload widths
  localparam int DATA_W  = 28;
  localparam int ELEM_W  = 16;
  localparam int BOUND_W = 7;
  localparam int SIZE_W  = 7;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // table size defaults
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int RESET_SIZE   = 64;

endpackage

>>> rtl/satq_ram.sv
// ----------------------------------------------------------------------------
// satq_ram
// Generic RAM: one write port, two read ports sharing a read enable,
// read data registered, held while no read is enabled.
// ----------------------------------------------------------------------------
module satq_ram #(
  parameter int WIDTH = satq_pkg::DATA_W,
  parameter int DEPTH = satq_pkg::DEF_MAX_ROWS * satq_pkg::DEF_MAX_COLS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/summed_area_table_query.sv
// ----------------------------------------------------------------------------
// summed_area_table_query
// Builds a 2D summed-area table from row-major loads and answers rectangle
// sum queries by inclusion and exclusion over four table reads.
// ----------------------------------------------------------------------------
// The table lives in one RAM of MAX_ROWS*MAX_COLS entries with one write port
// and two registered read ports; its contents are undefined after reset and
// there is no clearing pass, so queries must only touch entries loaded since
// reset. A load reads the entry above, then does the add and write-back. A
// query reads two corners at once on the two read ports, then the other two
// corners, then does the combine. One transaction is in flight at a time; the
// result register lets the next transaction be accepted while a result still
// waits on out_ready. Writing either size register restarts loading at the
// first row and column.
module summed_area_table_query #(
  parameter int MAX_ROWS = satq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = satq_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic signed [satq_pkg::ELEM_W-1:0]  in_element_value,
  input  logic [satq_pkg::BOUND_W-1:0]        in_top_row,
  input  logic [satq_pkg::BOUND_W-1:0]        in_left_col,
  input  logic [satq_pkg::BOUND_W-1:0]        in_bottom_row,
  input  logic [satq_pkg::BOUND_W-1:0]        in_right_col,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [satq_pkg::DATA_W-1:0]  out_result_value,
  output logic                                out_was_query,
  output logic                                out_error_flag,
  // configuration port
  input  logic                                cfg_wr_en,
  input  logic [satq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [satq_pkg::SIZE_W-1:0]         cfg_wdata
);

  localparam int DATA_W  = satq_pkg::DATA_W;
  localparam int ELEM_W  = satq_pkg::ELEM_W;
  localparam int BOUND_W = satq_pkg::BOUND_W;
  localparam int SIZE_W  = satq_pkg::SIZE_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RC_W    = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
  localparam int CMP_W   = (RC_W > SIZE_W) ? RC_W : SIZE_W;
  localparam int IDX_W0  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int IDX_W   = (IDX_W0 > BOUND_W) ? IDX_W0 : BOUND_W;
  localparam int RS_W0   = ELEM_W + COL_W;
  localparam int RS_W    = (RS_W0 < DATA_W) ? RS_W0 : DATA_W;
  localparam int ROWS_RST_I = (MAX_ROWS < satq_pkg::RESET_SIZE) ? MAX_ROWS
                                                                : satq_pkg::RESET_SIZE;
  localparam int COLS_RST_I = (MAX_COLS < satq_pkg::RESET_SIZE) ? MAX_COLS
                                                                : satq_pkg::RESET_SIZE;
  localparam logic [SIZE_W-1:0] ROWS_RST = SIZE_W'(ROWS_RST_I);
  localparam logic [SIZE_W-1:0] COLS_RST = SIZE_W'(COLS_RST_I);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_QRY1,
    S_QRY2
  } state_t;

  // table address of zero-based row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // registers
  state_t                      state_r, state_nxt;
  logic [SIZE_W-1:0]           rows_r, rows_nxt;
  logic [SIZE_W-1:0]           cols_r, cols_nxt;
  logic [ROW_W-1:0]            load_row_r, load_row_nxt;
  logic [COL_W-1:0]            load_col_r, load_col_nxt;
  logic signed [RS_W-1:0]      rowsum_r, rowsum_nxt;
  logic [ROW_W-1:0]            cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]            cur_col_r, cur_col_nxt;
  logic signed [ELEM_W-1:0]    elem_r, elem_nxt;
  logic [BOUND_W-1:0]          top_r, top_nxt;
  logic [BOUND_W-1:0]          right_r, right_nxt;
  logic                        zero_a_r, zero_a_nxt;
  logic                        zero_b_r, zero_b_nxt;
  logic                        zero_c_r, zero_c_nxt;
  logic                        zero_d_r, zero_d_nxt;
  logic                        err_r, err_nxt;
  logic [DATA_W-1:0]           part_r, part_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]           out_value_r, out_value_nxt;
  logic                        out_query_r, out_query_nxt;
  logic                        out_err_r, out_err_nxt;

  // ram interface
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [DATA_W-1:0]           ram_wdata;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_raddr_a;
  logic [ADDR_W-1:0]           ram_raddr_b;
  logic [DATA_W-1:0]           ram_rdata_a;
  logic [DATA_W-1:0]           ram_rdata_b;

  // datapath helpers
  logic                        out_free;
  logic                        load_restart;
  logic [ROW_W-1:0]            eff_row;
  logic [COL_W-1:0]            eff_col;
  logic                        query_ok;
  logic signed [RS_W-1:0]      elem_ext;
  logic signed [RS_W-1:0]      rs_base;
  logic signed [RS_W-1:0]      rs_sum;
  logic [DATA_W-1:0]           rs_sum_ext;
  logic [DATA_W-1:0]           load_sum;
  logic [DATA_W-1:0]           query_sum;
  logic [CMP_W-1:0]            col_inc;
  logic [CMP_W-1:0]            row_inc;
  logic [SIZE_W-1:0]           cfg_size;
  logic [BOUND_W-1:0]          bottom_m1;
  logic [BOUND_W-1:0]          right_m1;
  logic [BOUND_W-1:0]          left_m2;
  logic [BOUND_W-1:0]          top_m2;

  satq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // handshake outputs
  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_was_query    = out_query_r;
  assign out_error_flag   = out_err_r;
  assign out_free         = !out_valid_r || out_ready;

  // load position, restarting when it lies outside the current size
  assign load_restart = (CMP_W'(load_row_r) >= CMP_W'(rows_r)) ||
                        (CMP_W'(load_col_r) >= CMP_W'(cols_r));
  assign eff_row = load_restart ? '0 : load_row_r;
  assign eff_col = load_restart ? '0 : load_col_r;

  // query bound check
  assign query_ok = (in_top_row != '0) && (in_left_col != '0) &&
                    (in_top_row <= in_bottom_row) && (in_left_col <= in_right_col) &&
                    (CMP_W'(in_bottom_row) <= CMP_W'(rows_r)) &&
                    (CMP_W'(in_right_col) <= CMP_W'(cols_r));

  // one-based bounds to zero-based table indexes
  assign bottom_m1  = in_bottom_row - BOUND_W'(1);
  assign right_m1   = in_right_col - BOUND_W'(1);
  assign left_m2    = in_left_col - BOUND_W'(2);
  assign top_m2     = top_r - BOUND_W'(2);

  // running row sum and prefix value of a load
  assign elem_ext   = RS_W'(elem_r);
  assign rs_base    = (cur_col_r == '0) ? '0 : rowsum_r;
  assign rs_sum     = rs_base + elem_ext;
  assign rs_sum_ext = DATA_W'(rs_sum);
  assign load_sum   = rs_sum_ext + (zero_a_r ? '0 : ram_rdata_a);

  // final inclusion and exclusion of a query
  assign query_sum = part_r - (zero_c_r ? '0 : ram_rdata_a)
                            + (zero_d_r ? '0 : ram_rdata_b);

  // position after the current load
  assign col_inc = CMP_W'(cur_col_r) + CMP_W'(1);
  assign row_inc = CMP_W'(cur_row_r) + CMP_W'(1);

  // clamped size value of a register write
  assign cfg_size = (cfg_wdata == '0) ? SIZE_W'(1) :
                    (CMP_W'(cfg_wdata) > CMP_W'(MAX_ROWS) && cfg_index == satq_pkg::CFG_ROWS_IN_USE)
                      ? SIZE_W'(MAX_ROWS) :
                    (CMP_W'(cfg_wdata) > CMP_W'(MAX_COLS) && cfg_index == satq_pkg::CFG_COLS_IN_USE)
                      ? SIZE_W'(MAX_COLS) : cfg_wdata;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    rowsum_nxt    = rowsum_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    elem_nxt      = elem_r;
    top_nxt       = top_r;
    right_nxt     = right_r;
    zero_a_nxt    = zero_a_r;
    zero_b_nxt    = zero_b_r;
    zero_c_nxt    = zero_c_r;
    zero_d_nxt    = zero_d_r;
    err_nxt       = err_r;
    part_nxt      = part_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_query_nxt = out_query_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr_a   = '0;
    ram_raddr_b   = '0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ram_re = 1'b1;
          if (in_req_type == satq_pkg::REQ_LOAD) begin
            // read the entry one row above
            cur_row_nxt = eff_row;
            cur_col_nxt = eff_col;
            elem_nxt    = in_element_value;
            zero_a_nxt  = (eff_row == '0);
            ram_raddr_a = cell_addr(IDX_W'(eff_row) - IDX_W'(1), IDX_W'(eff_col));
            state_nxt   = S_LOAD;
          end else begin
            // read bottom-right and bottom-left corners
            err_nxt     = !query_ok;
            top_nxt     = in_top_row;
            right_nxt   = right_m1;
            zero_b_nxt  = (in_left_col == BOUND_W'(1));
            zero_c_nxt  = (in_top_row == BOUND_W'(1));
            zero_d_nxt  = (in_left_col == BOUND_W'(1)) || (in_top_row == BOUND_W'(1));
            elem_nxt    = ELEM_W'(left_m2);
            ram_raddr_a = cell_addr(IDX_W'(bottom_m1), IDX_W'(right_m1));
            ram_raddr_b = cell_addr(IDX_W'(bottom_m1), IDX_W'(left_m2));
            state_nxt   = S_QRY1;
          end
        end
      end

      S_LOAD: begin
        if (out_free) begin
          // write back the prefix value and present it
          ram_we        = 1'b1;
          ram_waddr     = cell_addr(IDX_W'(cur_row_r), IDX_W'(cur_col_r));
          ram_wdata     = load_sum;
          out_valid_nxt = 1'b1;
          out_value_nxt = load_sum;
          out_query_nxt = 1'b0;
          out_err_nxt   = 1'b0;
          if (col_inc >= CMP_W'(cols_r)) begin
            load_col_nxt = '0;
            rowsum_nxt   = '0;
            load_row_nxt = (row_inc >= CMP_W'(rows_r)) ? '0 : ROW_W'(row_inc);
          end else begin
            load_col_nxt = COL_W'(col_inc);
            load_row_nxt = cur_row_r;
            rowsum_nxt   = rs_sum;
          end
          state_nxt = S_IDLE;
        end
      end

      S_QRY1: begin
        // partial sum, then read top-right and top-left corners
        part_nxt    = ram_rdata_a - (zero_b_r ? '0 : ram_rdata_b);
        ram_re      = 1'b1;
        ram_raddr_a = cell_addr(IDX_W'(top_m2), IDX_W'(right_r));
        ram_raddr_b = cell_addr(IDX_W'(top_m2), IDX_W'(elem_r[BOUND_W-1:0]));
        state_nxt   = S_QRY2;
      end

      S_QRY2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = err_r ? '0 : query_sum;
          out_query_nxt = 1'b1;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register write restarts loading
    if (cfg_wr_en) begin
      case (cfg_index)
        satq_pkg::CFG_ROWS_IN_USE: rows_nxt = cfg_size;
        satq_pkg::CFG_COLS_IN_USE: cols_nxt = cfg_size;
        default: begin
        end
      endcase
      load_row_nxt = '0;
      load_col_nxt = '0;
      rowsum_nxt   = '0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      load_row_r  <= '0;
      load_col_r  <= '0;
      rowsum_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      rowsum_r    <= rowsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    elem_r      <= elem_nxt;
    top_r       <= top_nxt;
    right_r     <= right_nxt;
    zero_a_r    <= zero_a_nxt;
    zero_b_r    <= zero_b_nxt;
    zero_c_r    <= zero_c_nxt;
    zero_d_r    <= zero_d_nxt;
    err_r       <= err_nxt;
    part_r      <= part_nxt;
    out_value_r <= out_value_nxt;
    out_query_r <= out_query_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule
